// File: hw/rtl/lob_pkg.sv
package lob_pkg;

  localparam int unsigned MaxOrders = 1024;
  localparam int unsigned OrdAw     = $clog2(MaxOrders);
  localparam int unsigned MaxLevels = 64;
  localparam int unsigned LvlAw     = $clog2(MaxLevels);
  localparam int unsigned MaxShown  = 10;

  localparam int unsigned PriceW = 32;
  localparam int unsigned QtyW   = 31;
  localparam int unsigned IdW    = 63;
  localparam int unsigned CntW   = 11;
  // exact level sum: one full-scale quantity per order
  localparam int unsigned SumW   = QtyW + OrdAw + 1;

  localparam logic [1:0] KindAdd    = 2'd0;
  localparam logic [1:0] KindCancel = 2'd1;

  localparam logic [1:0] SideBid  = 2'd0;
  localparam logic [1:0] SideAsk  = 2'd1;
  localparam logic [1:0] SideNone = 2'd2;

  localparam logic [1:0] StOk       = 2'd0;
  localparam logic [1:0] StUnknown  = 2'd1;
  localparam logic [1:0] StOrdFull  = 2'd2;
  localparam logic [1:0] StLvlFull  = 2'd3;

  typedef struct packed {
    logic [1:0]        kind;
    logic [1:0]        side;
    logic [PriceW-1:0] price;
    logic [QtyW-1:0]   quantity;
    logic [IdW-1:0]    order_ref;
    logic [IdW-1:0]    timestamp;
  } lob_in_t;

  typedef struct packed {
    logic [3:0]        level;
    logic              bid_valid;
    logic [PriceW-1:0] bid_price;
    logic [QtyW-1:0]   bid_size;
    logic [CntW-1:0]   bid_orders;
    logic              ask_valid;
    logic [PriceW-1:0] ask_price;
    logic [QtyW-1:0]   ask_size;
    logic [CntW-1:0]   ask_orders;
    logic [IdW-1:0]    event_time;
    logic              last;
    logic [1:0]        status;
  } lob_out_t;

endpackage

// File: hw/rtl/lob_if.sv
interface lob_in_if;
  logic             valid;
  logic             ready;
  lob_pkg::lob_in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface lob_out_if;
  logic              valid;
  logic              ready;
  lob_pkg::lob_out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: hw/rtl/limit_order_book_top_levels.sv
// after reset a clearing pass sweeps every order table slot; no event is taken meanwhile
// one event at a time: the order table scan reads one entry per cycle and stops on a hit
// level search and shifts wait on each level entry visited; an event runs up to three searches
// each snapshot row reads its bid level, then its ask level, then waits for the output transfer;
// reset is asynchronous, active low, empties the book, levels_shown to 10
module limit_order_book_top_levels (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [3:0]      cfg_wdata_i,
  lob_in_if.sink          in_i,
  lob_out_if.source       out_o
);

  localparam int unsigned OrdAw  = lob_pkg::OrdAw;
  localparam int unsigned LvlAw  = lob_pkg::LvlAw;
  localparam int unsigned PriceW = lob_pkg::PriceW;
  localparam int unsigned QtyW   = lob_pkg::QtyW;
  localparam int unsigned IdW    = lob_pkg::IdW;
  localparam int unsigned CntW   = lob_pkg::CntW;
  localparam int unsigned SumW   = lob_pkg::SumW;
  localparam logic [OrdAw-1:0] LastSlot = OrdAw'(lob_pkg::MaxOrders - 1);
  localparam logic [LvlAw:0]   FullCnt  = (LvlAw + 1)'(lob_pkg::MaxLevels);
  localparam logic [3:0]       MaxRows  = 4'(lob_pkg::MaxShown);

  // one order table word
  typedef struct packed {
    logic              live;
    logic [IdW-1:0]    id;
    logic [PriceW-1:0] price;
    logic [QtyW-1:0]   qty;
    logic [1:0]        side;
  } ord_t;

  // one price level, both sides share the table: address is {ask, index}
  typedef struct packed {
    logic [PriceW-1:0] price;
    logic [SumW-1:0]   size;
    logic [CntW-1:0]   count;
  } lvl_t;

  typedef enum logic [1:0] {
    ST_ROOM,
    ST_LEAVE,
    ST_JOIN
  } step_e;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_OSCAN,
    S_ODEC,
    S_LSCAN,
    S_LDISP,
    S_LVGO,
    S_JNGO,
    S_SHDN,
    S_SHUP,
    S_AFTLV,
    S_OWR,
    S_RGO,
    S_RBID,
    S_RASK,
    S_ROUT
  } state_e;

  // order table with its registered read port
  ord_t               omem [lob_pkg::MaxOrders];
  ord_t               odata_q;
  logic               owe_q;
  logic [OrdAw-1:0]   owaddr_q;
  ord_t               owdata_q;
  logic [OrdAw-1:0]   oraddr_q;

  // level table, bids in the lower half and asks in the upper half
  lvl_t               lmem [2 * lob_pkg::MaxLevels];
  lvl_t               lrdata_q;
  logic               lwe_q;
  logic [LvlAw:0]     lwaddr_q;
  lvl_t               lwdata_q;
  logic [LvlAw:0]     lraddr_q;

  state_e             state_q;
  step_e              step_q;
  logic [3:0]         levels_q;
  logic [1:0]         kind_q;
  logic [1:0]         side_q;
  logic [PriceW-1:0]  price_q;
  logic [QtyW-1:0]    qty_q;
  logic [IdW-1:0]     id_q;
  logic [IdW-1:0]     ts_q;
  logic [3:0]         rows_q;
  logic [1:0]         status_q;
  logic [OrdAw-1:0]   clr_q;
  logic [OrdAw-1:0]   pidx_q;
  logic               ofirst_q;
  logic               found_q;
  logic               free_found_q;
  logic [OrdAw-1:0]   slot_q;
  logic [OrdAw-1:0]   free_q;
  logic [1:0]         old_side_q;
  logic [PriceW-1:0]  old_price_q;
  logic [QtyW-1:0]    old_qty_q;
  logic               ls_q;
  logic [PriceW-1:0]  lt_q;
  logic [LvlAw:0]     li_q;
  logic [1:0]         wt_q;
  logic               hit_q;
  logic [LvlAw:0]     pos_q;
  lvl_t               lvl_q;
  logic [LvlAw:0]     sh_q;
  logic [LvlAw:0]     used_q [2];
  logic [3:0]         row_q;
  lvl_t               bid_q;
  logic               out_valid_q;
  lob_pkg::lob_out_t  out_q;

  logic [LvlAw:0]     used_cur;
  logic [LvlAw:0]     sh_inc;
  logic [LvlAw:0]     sh_dec;
  logic [LvlAw:0]     row_ext;
  logic               old_lvl;
  logic               new_lvl;
  logic [3:0]         rows_clamped;
  logic [SumW-1:0]    leave_size;
  lob_pkg::lob_out_t  row_out;

  // true if price a ranks ahead of price b on the given side
  function automatic logic ahead(input logic ask, input logic [PriceW-1:0] a,
                                 input logic [PriceW-1:0] b);
    ahead = ask ? (a < b) : (a > b);
  endfunction

  function automatic logic [QtyW-1:0] sat_size(input logic [SumW-1:0] s);
    sat_size = (|s[SumW-1:QtyW]) ? {QtyW{1'b1}} : s[QtyW-1:0];
  endfunction

  assign used_cur = used_q[ls_q];
  assign sh_inc   = sh_q + 1'b1;
  assign sh_dec   = sh_q - 1'b1;
  assign row_ext  = (LvlAw + 1)'(row_q);
  assign old_lvl  = (old_side_q != lob_pkg::SideNone);
  assign new_lvl  = (side_q != lob_pkg::SideNone);

  assign leave_size = (lvl_q.size >= SumW'(old_qty_q)) ? lvl_q.size - SumW'(old_qty_q)
                                                       : '0;

  // depth register clamped into 1 .. max rows
  always_comb begin
    rows_clamped = levels_q;
    if (levels_q == 4'd0) begin
      rows_clamped = 4'd1;
    end else if (levels_q > MaxRows) begin
      rows_clamped = MaxRows;
    end
  end

  // snapshot row from the latched bid level and the ask level just read
  always_comb begin
    row_out            = '0;
    row_out.level      = row_q;
    row_out.event_time = ts_q;
    row_out.status     = status_q;
    row_out.last       = ((row_q + 4'd1) == rows_q);
    if (row_ext < used_q[0]) begin
      row_out.bid_valid  = 1'b1;
      row_out.bid_price  = bid_q.price;
      row_out.bid_size   = sat_size(bid_q.size);
      row_out.bid_orders = bid_q.count;
    end
    if (row_ext < used_q[1]) begin
      row_out.ask_valid  = 1'b1;
      row_out.ask_price  = lrdata_q.price;
      row_out.ask_size   = sat_size(lrdata_q.size);
      row_out.ask_orders = lrdata_q.count;
    end
  end

  assign in_i.ready  = (state_q == S_IDLE);
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  // order table storage
  always_ff @(posedge clk_i) begin
    if (owe_q) begin
      omem[owaddr_q] <= owdata_q;
    end
    odata_q <= omem[oraddr_q];
  end

  // level table storage
  always_ff @(posedge clk_i) begin
    if (lwe_q) begin
      lmem[lwaddr_q] <= lwdata_q;
    end
    lrdata_q <= lmem[lraddr_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      step_q       <= ST_ROOM;
      levels_q     <= 4'd10;
      clr_q        <= '0;
      owe_q        <= 1'b0;
      lwe_q        <= 1'b0;
      used_q[0]    <= '0;
      used_q[1]    <= '0;
      out_valid_q  <= 1'b0;
      wt_q         <= '0;
      ofirst_q     <= 1'b1;
      found_q      <= 1'b0;
      free_found_q <= 1'b0;
      hit_q        <= 1'b0;
    end else begin
      owe_q <= 1'b0;
      lwe_q <= 1'b0;
      if (cfg_we_i) begin
        levels_q <= cfg_wdata_i;
      end

      unique case (state_q)
        // sweep every order slot to not live
        S_CLEAR: begin
          owe_q    <= 1'b1;
          owaddr_q <= clr_q;
          owdata_q <= '0;
          clr_q    <= clr_q + 1'b1;
          if (clr_q == LastSlot) begin
            state_q <= S_IDLE;
          end
        end

        S_IDLE: begin
          if (in_i.valid) begin
            kind_q   <= in_i.data.kind;
            side_q   <= (in_i.data.side == lob_pkg::SideAsk) ? lob_pkg::SideAsk :
                        (in_i.data.side == lob_pkg::SideBid) ? lob_pkg::SideBid :
                                                               lob_pkg::SideNone;
            price_q  <= in_i.data.price;
            qty_q    <= in_i.data.quantity;
            id_q     <= in_i.data.order_ref;
            ts_q     <= in_i.data.timestamp;
            rows_q   <= rows_clamped;
            status_q <= lob_pkg::StOk;
            found_q      <= 1'b0;
            free_found_q <= 1'b0;
            oraddr_q     <= '0;
            ofirst_q     <= 1'b1;
            if (in_i.data.kind == lob_pkg::KindAdd || in_i.data.kind == lob_pkg::KindCancel) begin
              state_q <= S_OSCAN;
            end else begin
              state_q <= S_RGO;
            end
          end
        end

        // one slot per cycle, data comes back in the cycle after its address
        S_OSCAN: begin
          oraddr_q <= oraddr_q + 1'b1;
          pidx_q   <= oraddr_q;
          ofirst_q <= 1'b0;
          if (!ofirst_q) begin
            if (odata_q.live && odata_q.id == id_q) begin
              found_q     <= 1'b1;
              slot_q      <= pidx_q;
              old_side_q  <= odata_q.side;
              old_price_q <= odata_q.price;
              old_qty_q   <= odata_q.qty;
              state_q     <= S_ODEC;
            end else begin
              if (!odata_q.live && !free_found_q) begin
                free_found_q <= 1'b1;
                free_q       <= pidx_q;
              end
              if (pidx_q == LastSlot) begin
                state_q <= S_ODEC;
              end
            end
          end
        end

        S_ODEC: begin
          if (kind_q == lob_pkg::KindCancel) begin
            if (!found_q) begin
              status_q <= lob_pkg::StUnknown;
              state_q  <= S_RGO;
            end else if (old_lvl) begin
              state_q <= S_LVGO;
            end else begin
              state_q <= S_OWR;
            end
          end else if (!found_q && !free_found_q) begin
            status_q <= lob_pkg::StOrdFull;
            state_q  <= S_RGO;
          end else begin
            if (!found_q) begin
              slot_q <= free_q;
            end
            if (new_lvl) begin
              ls_q    <= (side_q == lob_pkg::SideAsk);
              lt_q    <= price_q;
              step_q  <= ST_ROOM;
              li_q    <= '0;
              wt_q    <= '0;
              state_q <= S_LSCAN;
            end else if (found_q && old_lvl) begin
              state_q <= S_LVGO;
            end else begin
              state_q <= S_OWR;
            end
          end
        end

        // walk the sorted side until a price no longer ranks ahead of the target
        S_LSCAN: begin
          if (wt_q == 2'd0) begin
            if (li_q == used_cur) begin
              hit_q   <= 1'b0;
              pos_q   <= li_q;
              state_q <= S_LDISP;
            end else begin
              lraddr_q <= {ls_q, li_q[LvlAw-1:0]};
              wt_q     <= 2'd1;
            end
          end else if (wt_q != 2'd3) begin
            wt_q <= wt_q + 2'd1;
          end else begin
            wt_q <= 2'd0;
            if (!ahead(ls_q, lrdata_q.price, lt_q)) begin
              hit_q   <= (lrdata_q.price == lt_q);
              pos_q   <= li_q;
              lvl_q   <= lrdata_q;
              state_q <= S_LDISP;
            end else begin
              li_q <= li_q + 1'b1;
            end
          end
        end

        S_LDISP: begin
          unique case (step_q)
            ST_ROOM: begin
              if (!hit_q && used_cur == FullCnt) begin
                status_q <= lob_pkg::StLvlFull;
                state_q  <= S_RGO;
              end else if (found_q && old_lvl) begin
                state_q <= S_LVGO;
              end else begin
                state_q <= S_JNGO;
              end
            end
            ST_LEAVE: begin
              if (!hit_q) begin
                state_q <= S_AFTLV;
              end else if (lvl_q.count > CntW'(1)) begin
                lwe_q          <= 1'b1;
                lwaddr_q       <= {ls_q, pos_q[LvlAw-1:0]};
                lwdata_q.price <= lvl_q.price;
                lwdata_q.size  <= leave_size;
                lwdata_q.count <= lvl_q.count - 1'b1;
                state_q        <= S_AFTLV;
              end else begin
                sh_q    <= pos_q;
                wt_q    <= 2'd0;
                state_q <= S_SHDN;
              end
            end
            ST_JOIN: begin
              if (hit_q) begin
                lwe_q          <= 1'b1;
                lwaddr_q       <= {ls_q, pos_q[LvlAw-1:0]};
                lwdata_q.price <= lvl_q.price;
                lwdata_q.size  <= lvl_q.size + SumW'(qty_q);
                lwdata_q.count <= lvl_q.count + 1'b1;
                state_q        <= S_OWR;
              end else begin
                sh_q    <= used_cur;
                wt_q    <= 2'd0;
                state_q <= S_SHUP;
              end
            end
            default: state_q <= S_RGO;
          endcase
        end

        S_LVGO: begin
          ls_q    <= (old_side_q == lob_pkg::SideAsk);
          lt_q    <= old_price_q;
          step_q  <= ST_LEAVE;
          li_q    <= '0;
          wt_q    <= '0;
          state_q <= S_LSCAN;
        end

        S_JNGO: begin
          ls_q    <= (side_q == lob_pkg::SideAsk);
          lt_q    <= price_q;
          step_q  <= ST_JOIN;
          li_q    <= '0;
          wt_q    <= '0;
          state_q <= S_LSCAN;
        end

        // close the gap left by an emptied level
        S_SHDN: begin
          if (wt_q == 2'd0) begin
            if (sh_inc >= used_cur) begin
              used_q[ls_q] <= used_cur - 1'b1;
              state_q      <= S_AFTLV;
            end else begin
              lraddr_q <= {ls_q, sh_inc[LvlAw-1:0]};
              wt_q     <= 2'd1;
            end
          end else if (wt_q != 2'd3) begin
            wt_q <= wt_q + 2'd1;
          end else begin
            lwe_q    <= 1'b1;
            lwaddr_q <= {ls_q, sh_q[LvlAw-1:0]};
            lwdata_q <= lrdata_q;
            sh_q     <= sh_inc;
            wt_q     <= 2'd0;
          end
        end

        // open a hole at the insertion point, then drop the new level in
        S_SHUP: begin
          if (wt_q == 2'd0) begin
            if (sh_q == pos_q) begin
              lwe_q          <= 1'b1;
              lwaddr_q       <= {ls_q, pos_q[LvlAw-1:0]};
              lwdata_q.price <= lt_q;
              lwdata_q.size  <= SumW'(qty_q);
              lwdata_q.count <= CntW'(1);
              used_q[ls_q]   <= used_cur + 1'b1;
              state_q        <= S_OWR;
            end else begin
              lraddr_q <= {ls_q, sh_dec[LvlAw-1:0]};
              wt_q     <= 2'd1;
            end
          end else if (wt_q != 2'd3) begin
            wt_q <= wt_q + 2'd1;
          end else begin
            lwe_q    <= 1'b1;
            lwaddr_q <= {ls_q, sh_q[LvlAw-1:0]};
            lwdata_q <= lrdata_q;
            sh_q     <= sh_dec;
            wt_q     <= 2'd0;
          end
        end

        S_AFTLV: begin
          if (kind_q == lob_pkg::KindAdd && new_lvl) begin
            state_q <= S_JNGO;
          end else begin
            state_q <= S_OWR;
          end
        end

        S_OWR: begin
          owe_q    <= 1'b1;
          owaddr_q <= slot_q;
          owdata_q.live  <= (kind_q == lob_pkg::KindAdd);
          owdata_q.id    <= id_q;
          owdata_q.price <= price_q;
          owdata_q.qty   <= qty_q;
          owdata_q.side  <= side_q;
          state_q  <= S_RGO;
        end

        S_RGO: begin
          row_q   <= '0;
          wt_q    <= '0;
          state_q <= S_RBID;
        end

        S_RBID: begin
          if (wt_q == 2'd0) begin
            lraddr_q <= {1'b0, row_ext[LvlAw-1:0]};
            wt_q     <= 2'd1;
          end else if (wt_q != 2'd3) begin
            wt_q <= wt_q + 2'd1;
          end else begin
            bid_q   <= lrdata_q;
            wt_q    <= 2'd0;
            state_q <= S_RASK;
          end
        end

        S_RASK: begin
          if (wt_q == 2'd0) begin
            lraddr_q <= {1'b1, row_ext[LvlAw-1:0]};
            wt_q     <= 2'd1;
          end else if (wt_q != 2'd3) begin
            wt_q <= wt_q + 2'd1;
          end else begin
            out_q       <= row_out;
            out_valid_q <= 1'b1;
            wt_q        <= 2'd0;
            state_q     <= S_ROUT;
          end
        end

        // hold the row until the sink takes the transfer
        S_ROUT: begin
          if (out_o.ready) begin
            out_valid_q <= 1'b0;
            if ((row_q + 4'd1) == rows_q) begin
              state_q <= S_IDLE;
            end else begin
              row_q   <= row_q + 4'd1;
              state_q <= S_RBID;
            end
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// File: tb/sv/limit_order_book_top_levels_tb.sv
`timescale 1ns / 100ps

module limit_order_book_top_levels_tb;

  localparam int unsigned MaxOrders = lob_pkg::MaxOrders;
  localparam int unsigned MaxLevels = lob_pkg::MaxLevels;
  localparam int unsigned MaxShown  = lob_pkg::MaxShown;
  localparam int unsigned PriceW    = lob_pkg::PriceW;
  localparam int unsigned QtyW      = lob_pkg::QtyW;
  localparam int unsigned IdW       = lob_pkg::IdW;
  localparam int unsigned CntW      = lob_pkg::CntW;

  localparam logic [1:0] KindAdd    = lob_pkg::KindAdd;
  localparam logic [1:0] KindCancel = lob_pkg::KindCancel;
  localparam logic [1:0] SideBid    = lob_pkg::SideBid;
  localparam logic [1:0] SideAsk    = lob_pkg::SideAsk;
  localparam logic [1:0] SideNone   = lob_pkg::SideNone;
  localparam logic [1:0] StOk       = lob_pkg::StOk;
  localparam logic [1:0] StUnknown  = lob_pkg::StUnknown;
  localparam logic [1:0] StLvlFull  = lob_pkg::StLvlFull;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [3:0] cfg_wdata_i;

  lob_in_if  ev_if ();
  lob_out_if row_if ();

  limit_order_book_top_levels u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (ev_if),
    .out_o       (row_if)
  );

  // clock, 20 ns period
  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  localparam int unsigned WatchdogCycles = 40000;
  localparam int unsigned HoldCycles     = 8000;
  localparam int unsigned RandomPerPhase = 90;
  localparam logic [1:0]  KindOther      = 2'd2;
  localparam logic [1:0]  KindSpare      = 2'd3;
  localparam logic [1:0]  SideSpare      = 2'd3;

  // shadow book
  logic [IdW-1:0]    ord_id    [MaxOrders];
  logic [PriceW-1:0] ord_price [MaxOrders];
  logic [QtyW-1:0]   ord_qty   [MaxOrders];
  logic [1:0]        ord_side  [MaxOrders];
  bit                ord_live  [MaxOrders];
  logic [PriceW-1:0] lvl_price [2][MaxLevels];
  logic [63:0]       lvl_sum   [2][MaxLevels];
  int unsigned       lvl_cnt   [2][MaxLevels];
  int unsigned       lvl_used  [2];
  int unsigned       depth_shown;

  lob_pkg::lob_out_t snapshot_q[$];
  int unsigned err_cnt;
  int unsigned in_idle_pct;
  int unsigned out_idle_pct;
  bit          hold_req;
  bit          timed_out;

  task automatic report(input string what, input logic [63:0] exp_v, input logic [63:0] got_v);
    $display("mismatch %s: expected %0h got %0h", what, exp_v, got_v);
    err_cnt++;
  endtask

  function automatic int level_find(input int s, input logic [PriceW-1:0] p);
    for (int i = 0; i < lvl_used[s]; i++)
      if (lvl_price[s][i] == p) return i;
    return -1;
  endfunction

  function automatic bit ranks_ahead(input int s, input logic [PriceW-1:0] a,
                                     input logic [PriceW-1:0] b);
    return (s == SideBid) ? (a > b) : (a < b);
  endfunction

  function automatic void level_join(input int s, input logic [PriceW-1:0] p,
                                     input logic [QtyW-1:0] q);
    int idx;
    int pos;
    idx = level_find(s, p);
    if (idx >= 0) begin
      lvl_sum[s][idx] += q;
      lvl_cnt[s][idx] += 1;
      return;
    end
    pos = 0;
    while (pos < lvl_used[s] && ranks_ahead(s, lvl_price[s][pos], p)) pos++;
    for (int i = lvl_used[s]; i > pos; i--) begin
      lvl_price[s][i] = lvl_price[s][i-1];
      lvl_sum[s][i]   = lvl_sum[s][i-1];
      lvl_cnt[s][i]   = lvl_cnt[s][i-1];
    end
    lvl_price[s][pos] = p;
    lvl_sum[s][pos]   = q;
    lvl_cnt[s][pos]   = 1;
    lvl_used[s]++;
  endfunction

  function automatic void level_leave(input int s, input logic [PriceW-1:0] p,
                                      input logic [QtyW-1:0] q);
    int idx;
    idx = level_find(s, p);
    if (idx < 0) return;
    lvl_sum[s][idx] = (lvl_sum[s][idx] >= q) ? lvl_sum[s][idx] - q : 0;
    if (lvl_cnt[s][idx] > 1) begin
      lvl_cnt[s][idx] -= 1;
      return;
    end
    for (int i = idx; i + 1 < lvl_used[s]; i++) begin
      lvl_price[s][i] = lvl_price[s][i+1];
      lvl_sum[s][i]   = lvl_sum[s][i+1];
      lvl_cnt[s][i]   = lvl_cnt[s][i+1];
    end
    lvl_used[s]--;
  endfunction

  function automatic int order_find(input logic [IdW-1:0] id);
    for (int i = 0; i < MaxOrders; i++)
      if (ord_live[i] && ord_id[i] == id) return i;
    return -1;
  endfunction

  function automatic void order_unlink(input int slot);
    if (ord_side[slot] == SideBid || ord_side[slot] == SideAsk)
      level_leave(ord_side[slot], ord_price[slot], ord_qty[slot]);
  endfunction

  function automatic logic [1:0] book_add(input logic [1:0] side, input lob_pkg::lob_in_t ev);
    int slot;
    slot = order_find(ev.order_ref);
    if (slot < 0) begin
      for (int i = 0; i < MaxOrders && slot < 0; i++)
        if (!ord_live[i]) slot = i;
      if (slot < 0) return lob_pkg::StOrdFull;
    end
    if (side != SideNone && level_find(side, ev.price) < 0 && lvl_used[side] >= MaxLevels)
      return StLvlFull;
    if (ord_live[slot]) order_unlink(slot);
    if (side != SideNone) level_join(side, ev.price, ev.quantity);
    ord_id[slot]    = ev.order_ref;
    ord_price[slot] = ev.price;
    ord_qty[slot]   = ev.quantity;
    ord_side[slot]  = side;
    ord_live[slot]  = 1'b1;
    return StOk;
  endfunction

  // apply one event to the shadow book and queue the snapshot rows it yields
  function automatic void book_event(input lob_pkg::lob_in_t ev, input bit fix_st,
                                     input logic [1:0] typed_st);
    logic [1:0] side;
    logic [1:0] st;
    int slot;
    lob_pkg::lob_out_t r;
    side = (ev.side > SideNone) ? SideNone : ev.side;
    st = StOk;
    if (ev.kind == KindAdd) begin
      st = book_add(side, ev);
    end else if (ev.kind == KindCancel) begin
      slot = order_find(ev.order_ref);
      if (slot < 0) st = StUnknown;
      else begin
        order_unlink(slot);
        ord_live[slot] = 1'b0;
      end
    end
    if (fix_st) st = typed_st;
    for (int i = 0; i < depth_shown; i++) begin
      r = '0;
      r.level = 4'(i);
      if (i < lvl_used[SideBid]) begin
        r.bid_valid  = 1'b1;
        r.bid_price  = lvl_price[SideBid][i];
        r.bid_size   = (lvl_sum[SideBid][i] > 64'h7FFF_FFFF) ? '1 : QtyW'(lvl_sum[SideBid][i]);
        r.bid_orders = (lvl_cnt[SideBid][i] > 2047) ? '1 : CntW'(lvl_cnt[SideBid][i]);
      end
      if (i < lvl_used[SideAsk]) begin
        r.ask_valid  = 1'b1;
        r.ask_price  = lvl_price[SideAsk][i];
        r.ask_size   = (lvl_sum[SideAsk][i] > 64'h7FFF_FFFF) ? '1 : QtyW'(lvl_sum[SideAsk][i]);
        r.ask_orders = (lvl_cnt[SideAsk][i] > 2047) ? '1 : CntW'(lvl_cnt[SideAsk][i]);
      end
      r.event_time = ev.timestamp;
      r.last       = (i + 1 == depth_shown);
      r.status     = st;
      snapshot_q = {snapshot_q, r};
    end
  endfunction

  // offer one event, gap first, then wait for the transfer
  task automatic send_event(input lob_pkg::lob_in_t ev, input bit fix_st,
                            input logic [1:0] typed_st);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(99) < in_idle_pct) gap++;
    if (gap > 0) begin
      ev_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    ev_if.valid <= 1'b1;
    ev_if.data  <= ev;
    do @(posedge clk_i); while (!ev_if.ready);
    book_event(ev, fix_st, typed_st);
  endtask

  // write the depth register once the book has gone quiet
  task automatic set_depth(input logic [3:0] v);
    ev_if.valid <= 1'b0;
    wait (snapshot_q.size() == 0);
    repeat (50) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    depth_shown = (v == 0) ? 1 : (v > MaxShown) ? MaxShown : v;
  endtask

  function automatic lob_pkg::lob_in_t make_event(input logic [1:0] k, input logic [1:0] s,
                                                  input logic [PriceW-1:0] p,
                                                  input logic [QtyW-1:0] q,
                                                  input logic [IdW-1:0] id);
    lob_pkg::lob_in_t ev;
    ev.kind      = k;
    ev.side      = s;
    ev.price     = p;
    ev.quantity  = q;
    ev.order_ref = id;
    ev.timestamp = IdW'({$urandom, $urandom});
    return ev;
  endfunction

  // mostly a live-ish book: small id pool, narrow price band, extremes now and then
  function automatic lob_pkg::lob_in_t random_event();
    lob_pkg::lob_in_t ev;
    int unsigned pick;
    pick = $urandom_range(99);
    ev = make_event(KindAdd, 2'($urandom_range(1)), 32'd1000 + 32'($urandom_range(40)),
                    QtyW'($urandom_range(1000)), IdW'($urandom_range(47)));
    if (pick < 30) ev.kind = KindCancel;
    else if (pick < 35) ev.kind = $urandom_range(1) ? KindOther : KindSpare;
    if ($urandom_range(19) == 0) ev.side = 2'($urandom_range(3));
    if ($urandom_range(9) == 0) ev.price = $urandom;
    if ($urandom_range(9) == 0) ev.quantity = QtyW'($urandom);
    if ($urandom_range(19) == 0) ev.order_ref = IdW'({$urandom, $urandom});
    return ev;
  endfunction

  // result side: random stalls, plus one long hold-off counted here
  int unsigned hold_cnt;
  bit          hold_done;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_if.ready <= 1'b0;
      hold_cnt     <= 0;
      hold_done    <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_done    <= 1'b1;
      hold_cnt     <= HoldCycles;
      row_if.ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt     <= hold_cnt - 1;
      row_if.ready <= 1'b0;
    end else begin
      row_if.ready <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  // compare each result transfer with the oldest expected row
  always @(posedge clk_i) begin
    lob_pkg::lob_out_t exp_r;
    lob_pkg::lob_out_t got_r;
    if (rst_ni && row_if.valid && row_if.ready) begin
      got_r = row_if.data;
      if (snapshot_q.size() == 0) begin
        report("unexpected row transfer, level", '0, got_r.level);
      end else begin
        exp_r = snapshot_q.pop_front();
        if (got_r.level !== exp_r.level) report("level", exp_r.level, got_r.level);
        if (got_r.bid_valid !== exp_r.bid_valid)
          report("bid_valid", exp_r.bid_valid, got_r.bid_valid);
        if (got_r.bid_price !== exp_r.bid_price)
          report("bid_price", exp_r.bid_price, got_r.bid_price);
        if (got_r.bid_size !== exp_r.bid_size) report("bid_size", exp_r.bid_size, got_r.bid_size);
        if (got_r.bid_orders !== exp_r.bid_orders)
          report("bid_orders", exp_r.bid_orders, got_r.bid_orders);
        if (got_r.ask_valid !== exp_r.ask_valid)
          report("ask_valid", exp_r.ask_valid, got_r.ask_valid);
        if (got_r.ask_price !== exp_r.ask_price)
          report("ask_price", exp_r.ask_price, got_r.ask_price);
        if (got_r.ask_size !== exp_r.ask_size) report("ask_size", exp_r.ask_size, got_r.ask_size);
        if (got_r.ask_orders !== exp_r.ask_orders)
          report("ask_orders", exp_r.ask_orders, got_r.ask_orders);
        if (got_r.event_time !== exp_r.event_time)
          report("event_time", exp_r.event_time, got_r.event_time);
        if (got_r.last !== exp_r.last) report("last", exp_r.last, got_r.last);
        if (got_r.status !== exp_r.status) report("status", exp_r.status, got_r.status);
      end
    end
  end

  // watchdog on cycles without any transfer; allows for the clearing pass
  int unsigned quiet_cnt;
  always @(posedge clk_i) begin
    if ((ev_if.valid && ev_if.ready) || (row_if.valid && row_if.ready)) quiet_cnt <= 0;
    else quiet_cnt <= quiet_cnt + 1;
    if (quiet_cnt >= WatchdogCycles) timed_out <= 1'b1;
  end

  typedef struct {
    lob_pkg::lob_in_t ev;
    bit               fix_st;
    logic [1:0]       st;
  } stim_row_t;

  stim_row_t directed [15];

  initial begin
    rst_ni = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin
    wait (timed_out);
    $display("FAIL");
    $finish;
  end

  initial begin
    cfg_we_i     <= 1'b0;
    cfg_wdata_i  <= '0;
    ev_if.valid  <= 1'b0;
    ev_if.data   <= '0;
    in_idle_pct  = 0;
    out_idle_pct = 0;
    depth_shown  = MaxShown;
    wait (rst_ni);
    @(posedge clk_i);

    // directed table: typed status where it is obvious, else predicted
    directed = '{
      '{make_event(KindOther, SideBid, '0, '0, '0), 1'b1, StOk},
      '{make_event(KindCancel, SideAsk, 32'd5, 31'd5, 63'd99), 1'b1, StUnknown},
      '{make_event(KindAdd, SideBid, '1, '1, '1), 1'b1, StOk},
      '{make_event(KindAdd, SideBid, '1, '1, 63'd1), 1'b0, StOk},
      '{make_event(KindAdd, SideAsk, '0, 31'd1, 63'd2), 1'b1, StOk},
      '{make_event(KindAdd, SideAsk, 32'd10, 31'd7, 63'd3), 1'b0, StOk},
      '{make_event(KindAdd, SideNone, 32'd50, 31'd9, 63'd4), 1'b1, StOk},
      '{make_event(KindAdd, SideSpare, 32'd60, 31'd9, 63'd5), 1'b1, StOk},
      '{make_event(KindAdd, SideAsk, 32'd10, 31'd3, 63'd4), 1'b0, StOk},
      '{make_event(KindAdd, SideBid, 32'd20, 31'd4, 63'd2), 1'b0, StOk},
      '{make_event(KindCancel, SideNone, '0, '0, 63'd3), 1'b1, StOk},
      '{make_event(KindCancel, SideBid, '0, '0, 63'd3), 1'b1, StUnknown},
      '{make_event(KindCancel, SideSpare, '0, '0, 63'd5), 1'b1, StOk},
      '{make_event(KindSpare, SideAsk, '1, '1, 63'd2), 1'b1, StOk},
      '{make_event(KindCancel, SideAsk, '0, '0, '1), 1'b0, StOk}
    };
    foreach (directed[i]) send_event(directed[i].ev, directed[i].fix_st, directed[i].st);

    // fill the ask side to its last level, then one more new price
    set_depth(4'd1);
    for (int i = 0; i < MaxLevels; i++)
      send_event(make_event(KindAdd, SideAsk, 32'h8000_0000 + 32'(i), 31'd1,
                            63'd1000 + 63'(i)), 1'b0, StOk);
    send_event(make_event(KindAdd, SideAsk, 32'h9000_0000, 31'd1, 63'd2000), 1'b1, StLvlFull);
    send_event(make_event(KindAdd, SideAsk, 32'h9000_0000, 31'd1, 63'd1000), 1'b1, StLvlFull);
    for (int i = 0; i < MaxLevels; i++)
      send_event(make_event(KindCancel, SideAsk, '0, '0, 63'd1000 + 63'(i)), 1'b0, StOk);

    // random phases across depth settings and idling patterns
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin set_depth(4'd10); in_idle_pct = 0;  out_idle_pct = 0;  end
        1: begin set_depth(4'd15); in_idle_pct = 73; out_idle_pct = 0;  end
        2: begin set_depth(4'd0);  in_idle_pct = 0;  out_idle_pct = 73; end
        default: begin
          set_depth(4'($urandom_range(2, 9)));
          in_idle_pct = 22; out_idle_pct = 22;
        end
      endcase
      for (int n = 0; n < RandomPerPhase; n++) begin
        if (ph == 0 && n == 20) hold_req = 1'b1;
        // sender pause until the book has drained
        if (ph == 3 && n == 60) begin
          ev_if.valid <= 1'b0;
          wait (snapshot_q.size() == 0);
          @(posedge clk_i);
        end
        send_event(random_event(), 1'b0, StOk);
      end
    end

    ev_if.valid <= 1'b0;
    wait (snapshot_q.size() == 0);
    repeat (2000) @(posedge clk_i);
    if (err_cnt == 0 && snapshot_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
